// ===== rtl/kmh_pkg.sv =====
// ----------------------------------------------------------------------------
// kmh_pkg
// Shared types and codes for the k-way merge heap accumulator.
// ----------------------------------------------------------------------------
package kmh_pkg;

	localparam int MAX_SOURCES_DEF = 16;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_POP    = 2'd1;
	localparam logic [1:0] CMD_FLUSH  = 2'd2;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	localparam logic [2:0] RD_ZERO   = 3'd0;
	localparam logic [2:0] RD_LAST   = 3'd1;
	localparam logic [2:0] RD_PARENT = 3'd2;
	localparam logic [2:0] RD_LEFT   = 3'd3;
	localparam logic [2:0] RD_RIGHT  = 3'd4;

	localparam logic [39:0] WEIGHT_MAX = {40{1'b1}};

	typedef struct packed {
		logic [1:0]  cmd;
		logic [23:0] entry_first;
		logic [23:0] entry_second;
		logic [39:0] entry_weight;
		logic [3:0]  entry_source;
	} in_t;

	typedef struct packed {
		logic [23:0] out_first;
		logic [23:0] out_second;
		logic [39:0] out_weight;
		logic        out_written;
		logic [3:0]  top_source;
		logic        heap_empty;
		logic [1:0]  status;
	} out_t;

	typedef struct packed {
		logic [47:0] key;
		logic [39:0] weight;
		logic [3:0]  source;
	} heap_entry_t;

	typedef struct packed {
		logic       start;
		logic       wr_node;
		logic       up_step;
		logic       top_cap;
		logic       pop_load;
		logic       child_cap;
		logic       down_step;
		logic       out_load;
		logic [2:0] rd_sel;
	} ctl_cmd_t;

	typedef struct packed {
		logic [1:0] in_cmd;
		logic       full;
		logic       empty;
		logic       at_root;
		logic       up_swap;
		logic       leaf;
		logic       down_swap;
		logic       out_busy;
	} dp_stat_t;

endpackage

// ===== rtl/kmh_datapath.sv =====
// ----------------------------------------------------------------------------
// kmh_datapath
// Heap storage, sift datapath, held-record accumulator and result register.
// ----------------------------------------------------------------------------
module kmh_datapath import kmh_pkg::*; #(
	parameter int MAX_SOURCES = MAX_SOURCES_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  in_t      item,
	input  ctl_cmd_t cmd,
	output dp_stat_t stat,
	output logic     result_valid,
	input  logic     result_ready,
	output out_t     result
);

	localparam int IW = $clog2(MAX_SOURCES);
	localparam int CW = $clog2(MAX_SOURCES + 1);
	localparam int LW = IW + 2;

	heap_entry_t mem [MAX_SOURCES];
	heap_entry_t rdata_q, node_q, top_q, child_q, pick, wdata;
	logic [IW-1:0] pos_q, raddr, parent, last_idx, pick_idx;
	logic [LW-1:0] left, right;
	logic right_ok, pick_right, we;
	logic [CW-1:0] heap_count_q;
	logic [47:0] held_key_q;
	logic [39:0] held_weight_q, sat;
	logic [40:0] sum;
	logic held_valid_q, held_eq, result_valid_q;
	out_t res_q, res_d, res_fin, result_q;

	assign left     = {1'b0, pos_q, 1'b1};
	assign right    = left + LW'(1);
	assign right_ok = right < LW'(heap_count_q);
	assign parent   = (pos_q - IW'(1)) >> 1;
	assign last_idx = IW'(heap_count_q - CW'(1));

	always_comb begin
		unique case (cmd.rd_sel)
			RD_LAST:   raddr = last_idx;
			RD_PARENT: raddr = parent;
			RD_LEFT:   raddr = left[IW-1:0];
			RD_RIGHT:  raddr = right[IW-1:0];
			default:   raddr = '0;
		endcase
	end

	assign pick_right = right_ok && !(child_q.key < rdata_q.key);
	assign pick       = pick_right ? rdata_q : child_q;
	assign pick_idx   = pick_right ? right[IW-1:0] : left[IW-1:0];

	assign stat.in_cmd    = item.cmd;
	assign stat.full      = heap_count_q == CW'(MAX_SOURCES);
	assign stat.empty     = heap_count_q == '0;
	assign stat.at_root   = pos_q == '0;
	assign stat.up_swap   = rdata_q.key > node_q.key;
	assign stat.leaf      = left >= LW'(heap_count_q);
	assign stat.down_swap = node_q.key > pick.key;
	assign stat.out_busy  = result_valid_q && !result_ready;

	always_comb begin
		priority if (cmd.up_step && stat.up_swap) begin
			wdata = rdata_q;
		end else if (cmd.down_step && stat.down_swap) begin
			wdata = pick;
		end else begin
			wdata = node_q;
		end
	end
	assign we = cmd.wr_node | cmd.up_step | cmd.down_step;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[pos_q] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign sum     = {1'b0, held_weight_q} + {1'b0, top_q.weight};
	assign sat     = sum[40] ? WEIGHT_MAX : sum[39:0];
	assign held_eq = held_valid_q && (top_q.key == held_key_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_count_q   <= '0;
			held_key_q     <= '0;
			held_weight_q  <= '0;
			held_valid_q   <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				if (item.cmd == CMD_INSERT && !stat.full) begin
					heap_count_q <= heap_count_q + CW'(1);
				end
				if (item.cmd == CMD_FLUSH) begin
					held_valid_q <= 1'b0;
				end
			end
			if (cmd.pop_load) begin
				heap_count_q <= heap_count_q - CW'(1);
				if (held_eq) begin
					held_weight_q <= sat;
				end else begin
					held_key_q    <= top_q.key;
					held_weight_q <= top_q.weight;
					held_valid_q  <= 1'b1;
				end
			end
			if (cmd.out_load) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		res_d = res_q;
		if (cmd.start) begin
			res_d = '0;
			unique case (item.cmd)
				CMD_INSERT: begin
					if (stat.full) begin
						res_d.status = STAT_FULL;
					end
				end
				CMD_POP: begin
					if (stat.empty) begin
						res_d.status = STAT_EMPTY;
					end
				end
				CMD_FLUSH: begin
					if (held_valid_q) begin
						res_d.out_first   = held_key_q[47:24];
						res_d.out_second  = held_key_q[23:0];
						res_d.out_weight  = held_weight_q;
						res_d.out_written = 1'b1;
					end
				end
				default: ;
			endcase
		end
		if (cmd.pop_load) begin
			res_d.top_source = top_q.source;
			if (held_valid_q && !held_eq) begin
				res_d.out_first   = held_key_q[47:24];
				res_d.out_second  = held_key_q[23:0];
				res_d.out_weight  = held_weight_q;
				res_d.out_written = 1'b1;
			end
		end
	end

	always_comb begin
		res_fin            = res_q;
		res_fin.heap_empty = stat.empty;
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			node_q <= '{key: {item.entry_first, item.entry_second},
				weight: item.entry_weight, source: item.entry_source};
			if (item.cmd == CMD_INSERT && !stat.full) begin
				pos_q <= heap_count_q[IW-1:0];
			end
		end
		res_q <= res_d;
		if (cmd.top_cap) begin
			top_q <= rdata_q;
		end
		if (cmd.pop_load) begin
			node_q <= rdata_q;
			pos_q  <= '0;
		end
		if (cmd.up_step && stat.up_swap) begin
			pos_q <= parent;
		end
		if (cmd.child_cap) begin
			child_q <= rdata_q;
		end
		if (cmd.down_step && stat.down_swap) begin
			pos_q <= pick_idx;
		end
		if (cmd.out_load) begin
			result_q <= res_fin;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		heap_count_q <= CW'(MAX_SOURCES))
		else $error("heap count above capacity");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> (heap_count_q == $past(heap_count_q) ||
			heap_count_q == $past(heap_count_q) + CW'(1)))
		else $error("heap count moved by more than one on start");

	a_held_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(held_valid_q) |-> $past(cmd.start && item.cmd == CMD_FLUSH))
		else $error("held record dropped without flush");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !stat.out_busy)
		else $error("result register overwritten while pending");

	a_out_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> result_valid_q)
		else $error("loaded result not presented");
`endif

endmodule

// ===== rtl/kmh_ctrl.sv =====
// ----------------------------------------------------------------------------
// kmh_ctrl
// Sequencer for insert, pop-and-merge and flush transactions.
// ----------------------------------------------------------------------------
module kmh_ctrl import kmh_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_ready,
	input  dp_stat_t stat,
	output ctl_cmd_t cmd
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_U_CHK  = 4'd1;
	localparam logic [3:0] S_U_CMP  = 4'd2;
	localparam logic [3:0] S_P_TOP  = 4'd3;
	localparam logic [3:0] S_P_LAST = 4'd4;
	localparam logic [3:0] S_D_CHK  = 4'd5;
	localparam logic [3:0] S_D_RGT  = 4'd6;
	localparam logic [3:0] S_D_CMP  = 4'd7;
	localparam logic [3:0] S_FIN    = 4'd8;

	logic [3:0] state_q, state_d;

	assign item_ready = state_q == S_IDLE;

	always_comb begin
		cmd     = '0;
		cmd.rd_sel = RD_ZERO;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.start = 1'b1;
					unique case (stat.in_cmd)
						CMD_INSERT: state_d = stat.full ? S_FIN : S_U_CHK;
						CMD_POP:    state_d = stat.empty ? S_FIN : S_P_TOP;
						default:    state_d = S_FIN;
					endcase
				end
			end
			S_U_CHK: begin
				if (stat.at_root) begin
					cmd.wr_node = 1'b1;
					state_d     = S_FIN;
				end else begin
					cmd.rd_sel = RD_PARENT;
					state_d    = S_U_CMP;
				end
			end
			S_U_CMP: begin
				cmd.up_step = 1'b1;
				state_d     = stat.up_swap ? S_U_CHK : S_FIN;
			end
			S_P_TOP: begin
				cmd.top_cap = 1'b1;
				cmd.rd_sel  = RD_LAST;
				state_d     = S_P_LAST;
			end
			S_P_LAST: begin
				cmd.pop_load = 1'b1;
				state_d      = S_D_CHK;
			end
			S_D_CHK: begin
				if (stat.leaf) begin
					cmd.wr_node = 1'b1;
					state_d     = S_FIN;
				end else begin
					cmd.rd_sel = RD_LEFT;
					state_d    = S_D_RGT;
				end
			end
			S_D_RGT: begin
				cmd.child_cap = 1'b1;
				cmd.rd_sel    = RD_RIGHT;
				state_d       = S_D_CMP;
			end
			S_D_CMP: begin
				cmd.down_step = 1'b1;
				state_d       = stat.down_swap ? S_D_CHK : S_FIN;
			end
			S_FIN: begin
				if (!stat.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/kway_merge_heap_accumulate.sv =====
// Insert sifts the new entry up from the end of the heap one level at a time;
// pop captures the root, reloads the last entry and sifts it down. Flush, bad
// commands and rejected inserts or pops go straight to the result state.
// One transaction at a time; a stalled result holds the next transaction off.
// Reset clears heap count, held record and result valid; heap memory is not
// cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// kway_merge_heap_accumulate
// Binary min-heap k-way merge with held-record weight accumulation.
// ----------------------------------------------------------------------------
module kway_merge_heap_accumulate import kmh_pkg::*; #(
	parameter int MAX_SOURCES = MAX_SOURCES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_ready,
	input  in_t  item,
	output logic result_valid,
	input  logic result_ready,
	output out_t result
);

	ctl_cmd_t cmd;
	dp_stat_t stat;

	kmh_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	kmh_datapath #(
		.MAX_SOURCES (MAX_SOURCES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.stat         (stat),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
